FILE: src/hsl_pkg.sv
`default_nettype none

package hsl_pkg;

    // Default number of fraction bits of the internal fixed-point format.
    localparam int HSL_FRAC_BITS = 15;

    // Hue arithmetic, in whole degrees.
    localparam logic [9:0] HUE_WRAP    = 10'd360;
    localparam logic [9:0] HUE_THIRD   = 10'd120;
    localparam logic [9:0] HUE_2THIRDS = 10'd240;

    // Piece of the four-piece test that a channel falls into.
    localparam logic [1:0] PIECE_RAMP = 2'd0;  // t2 + round(D * k / 60)
    localparam logic [1:0] PIECE_T1   = 2'd1;  // flat top, t1
    localparam logic [1:0] PIECE_T2   = 2'd2;  // flat bottom, t2

    // Per-channel control that travels from the front end to a lane.
    typedef struct packed {
        logic [1:0] piece;
        logic [5:0] k;      // ramp weight, 0..60
    } chan_ctl_t;

    // Offset a hue that is already in 0..359 and wrap it back into 0..359.
    function automatic logic [8:0] wrap_hue(input logic [8:0] h, input logic [9:0] off);
        logic [9:0] sum;
        sum = {1'b0, h} + off;
        if (sum >= HUE_WRAP)
        begin
            sum = sum - HUE_WRAP;
        end
        return sum[8:0];
    endfunction

    // Sort a channel hue into its piece and derive the ramp weight.
    function automatic chan_ctl_t hue_to_ctl(input logic [8:0] deg);
        chan_ctl_t  ctl;
        logic [8:0] diff;
        diff = 9'(HUE_2THIRDS) - deg;
        if (deg < 9'd60)
        begin
            ctl.piece = PIECE_RAMP;
            ctl.k     = deg[5:0];
        end
        else if (deg < 9'd180)
        begin
            ctl.piece = PIECE_T1;
            ctl.k     = 6'd0;
        end
        else if (deg < 9'(HUE_2THIRDS))
        begin
            ctl.piece = PIECE_RAMP;
            ctl.k     = diff[5:0];
        end
        else
        begin
            ctl.piece = PIECE_T2;
            ctl.k     = 6'd0;
        end
        return ctl;
    endfunction

endpackage

`default_nettype wire

FILE: src/hsl_prep.sv
`default_nettype none

module hsl_prep
    import hsl_pkg::*;
#(
    parameter int FRAC_BITS = HSL_FRAC_BITS,
    localparam int QW = FRAC_BITS + 1,
    localparam int TW = FRAC_BITS + 3,
    localparam int MW = FRAC_BITS + 2
)
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [8:0]           hue_degrees,
    input  wire logic [6:0]           saturation_pct,
    input  wire logic [6:0]           lightness_pct,
    output logic signed [TW-1:0]      t1,
    output logic signed [TW-1:0]      t2,
    output logic [MW-1:0]             d_mag,
    output logic                      d_neg,
    output chan_ctl_t                 red_ctl,
    output chan_ctl_t                 green_ctl,
    output chan_ctl_t                 blue_ctl
);

    localparam int PW = 2 * FRAC_BITS + 2;
    localparam logic [QW:0]   Q_ONE  = (QW + 1)'(1) << FRAC_BITS;
    localparam logic [PW-1:0] P_HALF = PW'(1) << (FRAC_BITS - 1);

    // Percent to fixed point, round(pct * 2^F / 100), as a constant table.
    logic [QW-1:0] pct_lut [0:100];

    for (genvar i = 0; i <= 100; i++)
    begin : g_pct
        localparam longint unsigned PCT_Q =
            ((longint'(i) << FRAC_BITS) + 64'd50) / 64'd100;
        assign pct_lut[i] = QW'(PCT_Q);
    end

    // Stage 1: wrap the hue, clamp the percentages and look up S and L.
    logic [8:0]    hue_norm;
    logic [6:0]    sat_clamp;
    logic [6:0]    lig_clamp;
    logic [8:0]    hue_reg;
    logic [QW-1:0] s1_reg;
    logic [QW-1:0] l1_reg;
    logic          lt1_reg;

    assign hue_norm  = (hue_degrees >= 9'(HUE_WRAP)) ? hue_degrees - 9'(HUE_WRAP)
                                                     : hue_degrees;
    assign sat_clamp = (saturation_pct > 7'd100) ? 7'd100 : saturation_pct;
    assign lig_clamp = (lightness_pct > 7'd100) ? 7'd100 : lightness_pct;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg <= hue_norm;
            s1_reg  <= pct_lut[sat_clamp];
            l1_reg  <= pct_lut[lig_clamp];
            lt1_reg <= (lig_clamp < 7'd50);
        end
    end

    // Stage 2: one product, L*(1+S) for dark colors or L*S otherwise.
    logic [QW:0]     mul_b;
    logic [PW-1:0]   mul_p;
    logic [QW:0]     p2_reg;
    logic [QW-1:0]   s2_reg;
    logic [QW-1:0]   l2_reg;
    logic            lt2_reg;
    chan_ctl_t       red2_reg;
    chan_ctl_t       green2_reg;
    chan_ctl_t       blue2_reg;

    assign mul_b = lt1_reg ? (Q_ONE + (QW + 1)'(s1_reg)) : (QW + 1)'(s1_reg);
    assign mul_p = PW'(l1_reg) * PW'(mul_b) + P_HALF;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_reg     <= mul_p[FRAC_BITS +: QW + 1];
            s2_reg     <= s1_reg;
            l2_reg     <= l1_reg;
            lt2_reg    <= lt1_reg;
            red2_reg   <= hue_to_ctl(wrap_hue(hue_reg, HUE_THIRD));
            green2_reg <= hue_to_ctl(hue_reg);
            blue2_reg  <= hue_to_ctl(wrap_hue(hue_reg, HUE_2THIRDS));
        end
    end

    // Stage 3: the two temporaries and their difference D = t1 - t2.
    logic [TW-1:0]        p_ext;
    logic [TW-1:0]        l_ext;
    logic [TW-1:0]        s_ext;
    logic [TW-1:0]        t1_u;
    logic signed [TW-1:0] t1_s;
    logic signed [TW-1:0] t2_s;
    logic signed [TW-1:0] d_s;
    logic signed [TW-1:0] d_abs;
    logic signed [TW-1:0] t1_reg;
    logic signed [TW-1:0] t2_reg;
    logic [MW-1:0]        dmag_reg;
    logic                 dneg_reg;
    chan_ctl_t            red3_reg;
    chan_ctl_t            green3_reg;
    chan_ctl_t            blue3_reg;

    assign p_ext = TW'(p2_reg);
    assign l_ext = TW'(l2_reg);
    assign s_ext = TW'(s2_reg);
    assign t1_u  = lt2_reg ? p_ext : (l_ext + s_ext - p_ext);
    assign t1_s  = signed'(t1_u);
    assign t2_s  = signed'({l_ext[TW-2:0], 1'b0}) - t1_s;
    assign d_s   = t1_s - t2_s;
    assign d_abs = d_s[TW-1] ? -d_s : d_s;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg     <= t1_s;
            t2_reg     <= t2_s;
            dmag_reg   <= d_abs[MW-1:0];
            dneg_reg   <= d_s[TW-1];
            red3_reg   <= red2_reg;
            green3_reg <= green2_reg;
            blue3_reg  <= blue2_reg;
        end
    end

    assign t1        = t1_reg;
    assign t2        = t2_reg;
    assign d_mag     = dmag_reg;
    assign d_neg     = dneg_reg;
    assign red_ctl   = red3_reg;
    assign green_ctl = green3_reg;
    assign blue_ctl  = blue3_reg;

endmodule

`default_nettype wire

FILE: src/hsl_lane.sv
`default_nettype none

module hsl_lane
    import hsl_pkg::*;
#(
    parameter int FRAC_BITS = HSL_FRAC_BITS,
    localparam int TW = FRAC_BITS + 3,
    localparam int MW = FRAC_BITS + 2
)
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [TW-1:0] t1,
    input  wire logic signed [TW-1:0] t2,
    input  wire logic [MW-1:0]        d_mag,
    input  wire logic                 d_neg,
    input  wire chan_ctl_t            ctl,
    output logic [7:0]                level
);

    localparam int QW = FRAC_BITS + 1;
    localparam int YW = FRAC_BITS + 8;
    localparam int RW = FRAC_BITS + 3;
    localparam int CW = TW + 1;
    localparam int LW = QW + 8;
    localparam longint unsigned RECIP_L = (64'd1 << YW) / 64'd60;
    localparam logic [RW-1:0] RECIP  = RW'(RECIP_L);
    localparam logic [QW-1:0] Q_ONE  = QW'(1) << FRAC_BITS;
    localparam logic [LW-1:0] L_HALF = LW'(1) << (FRAC_BITS - 1);

    // Stage 4: scale |D| by the ramp weight.
    logic [YW-1:0]        num_reg;
    logic [1:0]           piece4_reg;
    logic                 neg4_reg;
    logic signed [TW-1:0] t14_reg;
    logic signed [TW-1:0] t24_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg    <= YW'(d_mag) * YW'(ctl.k);
            piece4_reg <= ctl.piece;
            neg4_reg   <= d_neg;
            t14_reg    <= t1;
            t24_reg    <= t2;
        end
    end

    // Stage 5: add half the divisor and multiply by the reciprocal of 60.
    logic [YW-1:0]        y_next;
    logic [YW+RW-1:0]     mq_reg;
    logic [YW-1:0]        y_reg;
    logic [1:0]           piece5_reg;
    logic                 neg5_reg;
    logic signed [TW-1:0] t15_reg;
    logic signed [TW-1:0] t25_reg;

    assign y_next = num_reg + YW'(30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mq_reg     <= (YW + RW)'(y_next) * (YW + RW)'(RECIP);
            y_reg      <= y_next;
            piece5_reg <= piece4_reg;
            neg5_reg   <= neg4_reg;
            t15_reg    <= t14_reg;
            t25_reg    <= t24_reg;
        end
    end

    // Stage 6: correct the estimate by one and pick the channel value.
    // The estimate is the true quotient or one short of it.
    logic [MW-1:0]        q_est;
    logic [YW-1:0]        rem;
    logic [MW-1:0]        quot;
    logic signed [CW-1:0] q_s;
    logic signed [CW-1:0] ramp;
    logic signed [CW-1:0] c_next;
    logic signed [CW-1:0] c_reg;

    assign q_est = mq_reg[YW +: MW];
    assign rem   = y_reg - YW'(q_est) * YW'(60);
    assign quot  = (rem >= YW'(60)) ? q_est + MW'(1) : q_est;
    assign q_s   = signed'(CW'(quot));
    assign ramp  = CW'(t25_reg) + (neg5_reg ? -q_s : q_s);

    always_comb
    begin
        case (piece5_reg)
            PIECE_RAMP: c_next = ramp;
            PIECE_T1:   c_next = CW'(t15_reg);
            default:    c_next = CW'(t25_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= c_next;
        end
    end

    // Stage 7: clamp to [0, 1] and scale to an 8-bit level, rounded half up.
    logic [QW-1:0] c_clamp;
    logic [LW-1:0] lvl_p;
    logic [8:0]    lvl_wide;
    logic [7:0]    level_reg;

    always_comb
    begin
        if (c_reg[CW-1])
        begin
            c_clamp = '0;
        end
        else if (c_reg > signed'(CW'(Q_ONE)))
        begin
            c_clamp = Q_ONE;
        end
        else
        begin
            c_clamp = c_reg[QW-1:0];
        end
    end

    assign lvl_p    = LW'(c_clamp) * LW'(255) + L_HALF;
    assign lvl_wide = lvl_p[FRAC_BITS +: 9];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            level_reg <= lvl_wide[8] ? 8'd255 : lvl_wide[7:0];
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire

FILE: src/hsl_to_rgb_converter_top.sv
// Channel   Direction  tdata fields (lowest bit first)
// s_axis    in         hue_degrees[8:0], saturation_pct[15:9], lightness_pct[22:16]
// m_axis    out        red_level[7:0], green_level[15:8], blue_level[23:16]
//
// One color enters per clock unless the output holds a result that is not taken;
// each color passes seven register stages: three in the shared front
// end and four in each of the three channel lanes.
// rst_n clears only the stage valid bits; the data registers carry no reset.
// When the output holds a result that is not taken, the whole pipeline holds
// and s_tready drops; empty stages still fill while the output is free.
`default_nettype none

module hsl_to_rgb_converter_top
    import hsl_pkg::*;
#(
    parameter int FRAC_BITS = HSL_FRAC_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // hue_degrees, saturation_pct, lightness_pct
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // red_level, green_level, blue_level
);

    localparam int TW     = FRAC_BITS + 3;
    localparam int MW     = FRAC_BITS + 2;
    localparam int STAGES = 7;

    // Pipeline advance: the whole pipeline moves unless a result is held.
    logic               en;
    logic [STAGES-1:0]  vld_reg;
    logic [STAGES-1:0]  vld_next;

    assign en       = m_tready || !vld_reg[STAGES-1];
    assign s_tready = en;
    assign vld_next = en ? {vld_reg[STAGES-2:0], s_tvalid} : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Shared front end: fixed-point S and L, temporaries and channel pieces.
    logic signed [TW-1:0] t1;
    logic signed [TW-1:0] t2;
    logic [MW-1:0]        d_mag;
    logic                 d_neg;
    chan_ctl_t            red_ctl;
    chan_ctl_t            green_ctl;
    chan_ctl_t            blue_ctl;

    hsl_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .clk            (clk),
        .en             (en),
        .hue_degrees    (s_tdata[8:0]),
        .saturation_pct (s_tdata[15:9]),
        .lightness_pct  (s_tdata[22:16]),
        .t1             (t1),
        .t2             (t2),
        .d_mag          (d_mag),
        .d_neg          (d_neg),
        .red_ctl        (red_ctl),
        .green_ctl      (green_ctl),
        .blue_ctl       (blue_ctl)
    );

    // One lane per color channel.
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;

    hsl_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_red (
        .clk   (clk),
        .en    (en),
        .t1    (t1),
        .t2    (t2),
        .d_mag (d_mag),
        .d_neg (d_neg),
        .ctl   (red_ctl),
        .level (red_level)
    );

    hsl_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_green (
        .clk   (clk),
        .en    (en),
        .t1    (t1),
        .t2    (t2),
        .d_mag (d_mag),
        .d_neg (d_neg),
        .ctl   (green_ctl),
        .level (green_level)
    );

    hsl_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_blue (
        .clk   (clk),
        .en    (en),
        .t1    (t1),
        .t2    (t2),
        .d_mag (d_mag),
        .d_neg (d_neg),
        .ctl   (blue_ctl),
        .level (blue_level)
    );

    assign m_tvalid = vld_reg[STAGES-1];
    assign m_tdata  = {blue_level, green_level, red_level};

`ifndef ASSERT_OFF
    // t1 never falls below L, so the difference D is never negative.
    a_d_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> !d_neg)
        else $error("negative t1 - t2 difference in front end");

    // A held output freezes every stage valid bit.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> vld_reg == $past(vld_reg))
        else $error("pipeline moved while output was held");

    // An item in the next-to-last stage reaches the output on the next advance.
    a_reach: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && vld_reg[STAGES-2] |=> m_tvalid)
        else $error("item lost before the output stage");
`endif

endmodule

`default_nettype wire

FILE: test/hsl_checker.sv
// Watches both streams of the HSL to RGB converter, predicts the color of
// every accepted input transfer and compares it with the output transfers in order.
module hsl_checker
    import hsl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,   // hue_degrees, saturation_pct, lightness_pct
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // red_level, green_level, blue_level
    output int               fail_count,
    output int               pending_count
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC    = HSL_FRAC_BITS;
    localparam longint Q_UNITY = longint'(1) << FRAC;
    localparam longint Q_HALF  = longint'(1) << (FRAC - 1);

    // One expected color together with the input that produced it.
    typedef struct {
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] lig;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_expect_t;

    rgb_expect_t rgb_expected[$];

    // Division by a positive divisor, rounded to nearest with ties away from zero.
    function automatic longint round_div(input longint num, input longint den);
        if (num >= 0)
        begin
            return (num + den / 2) / den;
        end
        return -((-num + den / 2) / den);
    endfunction

    // Fixed-point product of two nonnegative values, rounded half up.
    function automatic longint fx_mul(input longint a, input longint b);
        return (a * b + Q_HALF) >>> FRAC;
    endfunction

    // Clamp a channel value to [0, 1] and scale it to an 8-bit level.
    function automatic logic [7:0] fx_to_level(input longint c);
        longint v;
        if (c < 0)
        begin
            c = 0;
        end
        if (c > Q_UNITY)
        begin
            c = Q_UNITY;
        end
        v = (c * 255 + Q_HALF) >>> FRAC;
        if (v > 255)
        begin
            v = 255;
        end
        return 8'(v);
    endfunction

    // Four-piece test on a channel hue in whole degrees.
    function automatic longint channel_value(input int deg, input longint t1, input longint t2);
        longint span;
        span = t1 - t2;
        if (deg < 60)
        begin
            return t2 + round_div(span * deg, 60);
        end
        if (deg < 180)
        begin
            return t1;
        end
        if (deg < 240)
        begin
            return t2 + round_div(span * (240 - deg), 60);
        end
        return t2;
    endfunction

    // Expected RGB levels for one HSL color.
    function automatic rgb_expect_t predict_rgb(input logic [8:0] hue, input logic [6:0] sat,
                                                input logic [6:0] lig);
        rgb_expect_t e;
        int          h;
        int          s_pct;
        int          l_pct;
        longint      s_fx;
        longint      l_fx;
        longint      t1;
        longint      t2;
        e.hue = hue;
        e.sat = sat;
        e.lig = lig;
        h     = int'(hue);
        if (h >= int'(HUE_WRAP))
        begin
            h = h - int'(HUE_WRAP);
        end
        s_pct = (sat > 7'd100) ? 100 : int'(sat);
        l_pct = (lig > 7'd100) ? 100 : int'(lig);
        s_fx  = round_div(longint'(s_pct) * Q_UNITY, 100);
        l_fx  = round_div(longint'(l_pct) * Q_UNITY, 100);
        if (s_pct == 0)
        begin
            // A color with no saturation is a grey at the lightness.
            e.red   = fx_to_level(l_fx);
            e.green = e.red;
            e.blue  = e.red;
            return e;
        end
        if (l_pct < 50)
        begin
            t1 = fx_mul(l_fx, Q_UNITY + s_fx);
        end
        else
        begin
            t1 = l_fx + s_fx - fx_mul(l_fx, s_fx);
        end
        t2      = 2 * l_fx - t1;
        e.red   = fx_to_level(channel_value((h + int'(HUE_THIRD)) % int'(HUE_WRAP), t1, t2));
        e.green = fx_to_level(channel_value(h, t1, t2));
        e.blue  = fx_to_level(channel_value((h + int'(HUE_2THIRDS)) % int'(HUE_WRAP), t1, t2));
        return e;
    endfunction

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic check_level(input string name, input logic [7:0] got, input rgb_expect_t e,
                               input logic [7:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0d expected %0d for hue %0d sat %0d light %0d",
                                      name, got, want, e.hue, e.sat, e.lig));
        end
    endtask

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
    end

    // Compare each output transfer with the oldest prediction, then record new input.
    always @(posedge clk)
    begin
        rgb_expect_t e;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (rgb_expected.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected output transfer, data %06h", m_tdata));
                end
                else
                begin
                    e = rgb_expected.pop_front();
                    check_level("red", m_tdata[7:0], e, e.red);
                    check_level("green", m_tdata[15:8], e, e.green);
                    check_level("blue", m_tdata[23:16], e, e.blue);
                end
            end
            if (s_tvalid && s_tready)
            begin
                rgb_expected.push_back(predict_rgb(s_tdata[8:0], s_tdata[15:9], s_tdata[22:16]));
            end
            pending_count = rgb_expected.size();
        end
    end

endmodule

FILE: test/tb_hsl_to_rgb_converter_top.sv
// Drives colors into the converter with random gaps and back-pressure and
// gives the verdict from the checker's failure count.
module tb_hsl_to_rgb_converter_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PER_PHASE = 650;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    int          fail_count;
    int          pending_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    hsl_to_rgb_converter_top u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hsl_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver back-pressure, changed at every falling edge.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Guard against a hung pipeline.
    initial
    begin
        #1ms;
        $display("simulation failed");
        $finish;
    end

    // Offer one color after a random idle gap and hold it until the transfer.
    task automatic send_color(input logic [8:0] hue, input logic [6:0] sat,
                              input logic [6:0] lig);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, lig, sat, hue};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Mostly legal colors, with some out-of-range hues and percentages.
    task automatic send_random_color();
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] lig;
        int         pick;
        pick = $urandom_range(99);
        hue  = (pick < 85) ? 9'($urandom_range(359)) : 9'($urandom_range(511, 360));
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            sat = 7'd0;
        end
        else if (pick < 90)
        begin
            sat = 7'($urandom_range(100, 1));
        end
        else
        begin
            sat = 7'($urandom_range(127, 101));
        end
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            lig = 7'd0;
        end
        else if (pick < 10)
        begin
            lig = 7'd100;
        end
        else if (pick < 90)
        begin
            lig = 7'($urandom_range(99, 1));
        end
        else
        begin
            lig = 7'($urandom_range(127, 101));
        end
        send_color(hue, sat, lig);
    endtask

    // Reset, directed colors, three phases of random colors, then the verdict.
    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        send_idle_pct = 23;
        recv_idle_pct = 54;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Greys, primaries, sector edges and out-of-range inputs.
        send_color(9'd0, 7'd0, 7'd0);
        send_color(9'd0, 7'd0, 7'd100);
        send_color(9'd77, 7'd0, 7'd50);
        send_color(9'd0, 7'd100, 7'd50);
        send_color(9'd120, 7'd100, 7'd50);
        send_color(9'd240, 7'd100, 7'd50);
        send_color(9'd359, 7'd100, 7'd50);
        send_color(9'd60, 7'd100, 7'd50);
        send_color(9'd180, 7'd100, 7'd50);
        send_color(9'd30, 7'd50, 7'd25);
        send_color(9'd200, 7'd75, 7'd80);
        send_color(9'd300, 7'd100, 7'd100);
        send_color(9'd45, 7'd100, 7'd49);
        send_color(9'd45, 7'd100, 7'd50);
        send_color(9'd90, 7'd1, 7'd1);
        send_color(9'd210, 7'd99, 7'd99);
        send_color(9'd15, 7'd3, 7'd97);
        send_color(9'd75, 7'd100, 7'd0);
        send_color(9'd360, 7'd60, 7'd40);
        send_color(9'd511, 7'd127, 7'd0);
        send_color(9'd100, 7'd101, 7'd101);
        send_color(9'd0, 7'd127, 7'd127);
        send_color(9'd256, 7'd64, 7'd64);
        send_color(9'd425, 7'd0, 7'd127);

        for (int i = 0; i < RANDOM_PER_PHASE; i++)
        begin
            send_random_color();
        end
        send_idle_pct = 54;
        recv_idle_pct = 23;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
        begin
            send_random_color();
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
        begin
            send_random_color();
        end
        s_tvalid <= 1'b0;

        // Drain the pipeline, then watch for stray output transfers.
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
